### rtl/kpce_pkg.sv
// Key codes, result kinds and widths shared by the keypad cart entry parser.
package kpce_pkg;

	// keypad key codes (ASCII)
	localparam logic [7:0] KEY_ZERO     = 8'h30;
	localparam logic [7:0] KEY_NINE     = 8'h39;
	localparam logic [7:0] KEY_COMPLETE = 8'h43;
	localparam logic [7:0] KEY_CANCEL   = 8'h44;
	localparam logic [7:0] KEY_ADD      = 8'h45;
	localparam logic [7:0] KEY_SWITCH   = 8'h46;

	// field widths
	localparam int unsigned KEY_W   = 8;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned VALUE_W = 20;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned DATA_W  = 48;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

	// result kinds
	typedef enum logic [1:0] {
		EV_ADDED    = 2'd0,
		EV_ADDED_DONE = 2'd1,
		EV_DONE     = 2'd2,
		EV_CANCEL   = 2'd3
	} event_kind_t;

endpackage

### rtl/keypad_cart_entry_parser.sv
// Keypad cart entry parser: key items in, cart entry and completion events out.
// A key accepted into the input register is parsed combinationally; its result, if any,
// is captured in the result register and offered on the master side from there.
// Throughput: one key per cycle while the master side takes results; the input
// register and the result register each hold one item.
// Reset (arst_n low): empty cart, quantity entry, digit_limit back to 1000.
module keypad_cart_entry_parser
	import kpce_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration: digit_limit
	input  logic              cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	// key input
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [KEY_W-1:0]  s_tdata,   // [7:0] key_code
	// event output
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [19:0] entry_quantity, [39:20] item_number,
	                                     // [44:40] cart_count, [47:45] zero
	output logic [1:0]        m_tuser    // [1:0] event_kind
);

	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

	// configuration register
	logic [LIMIT_W-1:0] limit_q;

	// input stage
	logic              s1_valid_q;
	logic [KEY_W-1:0]  key_s1;

	// parser state
	logic              entering_q;
	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] held_q;
	logic [CNT_W-1:0]  cnt_q;

	// result register
	logic              out_valid_q;
	event_kind_t       kind_q;
	logic [VALUE_W-1:0] qty_q;
	logic [VALUE_W-1:0] item_q;
	logic [COUNT_W-1:0] count_q;

	// next state and result
	logic              advance;
	logic              emit;
	event_kind_t       kind_d;
	logic [VALUE_W-1:0] qty_d;
	logic [VALUE_W-1:0] item_d;
	logic [CNT_W-1:0]  cnt_res;
	logic              entering_d;
	logic [VALUE_W-1:0] value_d;
	logic [VALUE_W-1:0] held_d;
	logic [CNT_W-1:0]  cnt_d;
	logic              is_digit;
	logic              full;
	logic [VALUE_W-1:0] digit_value;

	// the parse stage moves when the result slot is free or being emptied
	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	assign is_digit = (key_s1 >= KEY_ZERO) && (key_s1 <= KEY_NINE);
	assign full     = (cnt_q >= CNT_MAX);
	// value * 10 + digit; value < 65536 here, so 20 bits hold it
	assign digit_value = (value_q << 3) + (value_q << 1)
		+ VALUE_W'(key_s1 - KEY_ZERO);

	// key decode
	always_comb begin
		emit       = 1'b0;
		kind_d     = EV_ADDED;
		qty_d      = '0;
		item_d     = '0;
		cnt_res    = '0;
		entering_d = entering_q;
		value_d    = value_q;
		held_d     = held_q;
		cnt_d      = cnt_q;
		if (full) begin
			if (key_s1 == KEY_CANCEL) begin
				emit   = 1'b1;
				kind_d = EV_CANCEL;
			end else if (key_s1 == KEY_COMPLETE) begin
				emit    = 1'b1;
				kind_d  = EV_DONE;
				cnt_res = cnt_q;
			end
			if (emit) begin
				entering_d = 1'b0;
				value_d    = '0;
				held_d     = '0;
				cnt_d      = '0;
			end
		end else if (is_digit && (value_q < VALUE_W'(limit_q))) begin
			value_d = digit_value;
		end else if (key_s1 == KEY_CANCEL) begin
			emit       = 1'b1;
			kind_d     = EV_CANCEL;
			entering_d = 1'b0;
			value_d    = '0;
			held_d     = '0;
			cnt_d      = '0;
		end else if (!entering_q) begin
			if (key_s1 == KEY_SWITCH) begin
				held_d     = value_q;
				value_d    = '0;
				entering_d = 1'b1;
			end
		end else if (key_s1 == KEY_ADD) begin
			emit       = 1'b1;
			kind_d     = EV_ADDED;
			qty_d      = held_q;
			item_d     = value_q;
			cnt_res    = cnt_q + 1'b1;
			cnt_d      = cnt_q + 1'b1;
			entering_d = 1'b0;
			value_d    = '0;
			held_d     = '0;
		end else if (key_s1 == KEY_COMPLETE) begin
			emit       = 1'b1;
			kind_d     = EV_ADDED_DONE;
			qty_d      = held_q;
			item_d     = value_q;
			cnt_res    = cnt_q + 1'b1;
			entering_d = 1'b0;
			value_d    = '0;
			held_d     = '0;
			cnt_d      = '0;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_s1 <= s_tdata;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entering_q <= 1'b0;
			value_q    <= '0;
			held_q     <= '0;
			cnt_q      <= '0;
		end else if (advance) begin
			entering_q <= entering_d;
			value_q    <= value_d;
			held_q     <= held_d;
			cnt_q      <= cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// cart_count carries the low bits of the count
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q  <= kind_d;
			qty_q   <= qty_d;
			item_q  <= item_d;
			count_q <= COUNT_W'(cnt_res);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {3'b000, count_q, item_q, qty_q};

	// the cart never holds more than MAX_ITEMS entries
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above MAX_ITEMS");

	// a cancel or a completion leaves an empty cart in quantity entry
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && (kind_d != EV_ADDED)) |=>
		(cnt_q == '0) && !entering_q && (value_q == '0) && (held_q == '0))
		else $error("cart not restarted after completion or cancel");

	// a cancel event carries no entry and an empty count
	a_cancel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == EV_CANCEL)) |->
		(qty_q == '0) && (item_q == '0) && (count_q == '0))
		else $error("cancel event with nonzero payload");

	// a pending result is never overwritten before it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> out_valid_q && $stable(qty_q) && $stable(item_q))
		else $error("pending result lost");

	// the input stage only stalls on a held key while a pending result is not taken
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && out_valid_q && !m_tready))
		else $error("input stalled without cause");

endmodule

### dv/tb.sv
// Self-checking testbench for the keypad cart entry parser: key streams in, predicted events out.
`timescale 1ns / 1ps

module tb
	import kpce_pkg::*;
();

	localparam int unsigned CART_MAX     = 16;
	localparam int unsigned SETTLE_CYC   = 6;
	localparam int unsigned HOLD_CYCLES  = 400;

	// one predicted event, fields as they appear on the master side
	typedef struct packed {
		event_kind_t          kind;
		logic [VALUE_W-1:0]   qty;
		logic [VALUE_W-1:0]   item;
		logic [COUNT_W-1:0]   count;
	} cart_event_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wr_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [KEY_W-1:0]    s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;
	logic [1:0]          m_tuser;

	// parser state as predicted
	logic [LIMIT_W-1:0]  cart_limit;
	bit                  cart_entering;
	logic [VALUE_W-1:0]  cart_running;
	logic [VALUE_W-1:0]  cart_held;
	int unsigned         cart_count;

	cart_event_t         pending_events[$];
	int unsigned         fails = 0;
	int unsigned         send_idle_pct = 0;
	int unsigned         recv_idle_pct = 0;
	int unsigned         hold_requests = 0;

	keypad_cart_entry_parser #(
		.MAX_ITEMS (CART_MAX)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always #5 clk = ~clk;

	// empty cart, back to quantity entry
	function automatic void clear_cart();
		cart_entering = 1'b0;
		cart_running  = '0;
		cart_held     = '0;
		cart_count    = 0;
	endfunction

	// advance the predicted parser by one key; returns 1 when an event is due
	function automatic bit parse_key(input logic [KEY_W-1:0] key, output cart_event_t ev);
		bit is_digit;
		is_digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
		ev = '0;
		// full cart: only complete and cancel count
		if (cart_count >= CART_MAX) begin
			if (key == KEY_CANCEL) begin
				clear_cart();
				ev.kind = EV_CANCEL;
				return 1'b1;
			end
			if (key == KEY_COMPLETE) begin
				ev.kind  = EV_DONE;
				ev.count = cart_count[COUNT_W-1:0];
				clear_cart();
				return 1'b1;
			end
			return 1'b0;
		end
		if (is_digit && cart_running < VALUE_W'(cart_limit)) begin
			cart_running = VALUE_W'(cart_running * 10 + (key - KEY_ZERO));
			return 1'b0;
		end
		if (key == KEY_CANCEL) begin
			clear_cart();
			ev.kind = EV_CANCEL;
			return 1'b1;
		end
		// quantity entry: only the switch key matters
		if (!cart_entering) begin
			if (key == KEY_SWITCH) begin
				cart_held     = cart_running;
				cart_running  = '0;
				cart_entering = 1'b1;
			end
			return 1'b0;
		end
		if (key == KEY_ADD) begin
			ev.kind  = EV_ADDED;
			ev.qty   = cart_held;
			ev.item  = cart_running;
			cart_count++;
			ev.count = cart_count[COUNT_W-1:0];
			cart_running  = '0;
			cart_held     = '0;
			cart_entering = 1'b0;
			return 1'b1;
		end
		if (key == KEY_COMPLETE) begin
			ev.kind  = EV_ADDED_DONE;
			ev.qty   = cart_held;
			ev.item  = cart_running;
			ev.count = 5'(cart_count + 1);
			clear_cart();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// random key, biased toward well-formed entries for the current state
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(999);
		if (cart_count >= CART_MAX) begin
			if (r < 150)
				return KEY_COMPLETE;
			if (r < 250)
				return KEY_CANCEL;
			return 8'($urandom_range(255));
		end
		if (r < 5)
			return KEY_CANCEL;
		if (r < 60)
			return 8'($urandom_range(255));
		if (r < 700)
			return KEY_ZERO + 8'($urandom_range(9));
		if (!cart_entering)
			return KEY_SWITCH;
		if (r < 985)
			return KEY_ADD;
		return KEY_COMPLETE;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	// offer one key and wait for it to be taken
	task automatic send_key(input logic [KEY_W-1:0] key);
		cart_event_t ev;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		do
			@(posedge clk);
		while (!s_tready);
		if (parse_key(key, ev))
			pending_events.push_back(ev);
	endtask

	// stop offering, wait for every predicted event, then let the pipeline settle
	task automatic drain_events();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		drain_events();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cart_limit  = value;
	endtask

	task automatic send_random_keys(input int unsigned n);
		repeat (n) send_key(pick_key());
	endtask

	task automatic send_digits(input int unsigned n);
		repeat (n) send_key(KEY_ZERO + 8'($urandom_range(9)));
	endtask

	// receiver: check each taken event, then choose ready for the next edge
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	always @(posedge clk) begin
		cart_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event: expected none, actual kind %0d data %h",
					$time, m_tuser, m_tdata);
				fails++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", want.kind, m_tuser);
				check_field("entry_quantity", want.qty, m_tdata[19:0]);
				check_field("item_number", want.item, m_tdata[39:20]);
				check_field("cart_count", want.count, m_tdata[44:40]);
				check_field("padding", 0, m_tdata[47:45]);
			end
		end
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// extremes of the key field, stray keys, limit saturation, added, added-done and cancel events
	task automatic test_directed();
		send_key(8'h00);
		send_key(8'hFF);
		send_key(KEY_ADD);        // ignored during quantity entry
		send_key(KEY_COMPLETE);   // ignored during quantity entry
		repeat (5) send_key(KEY_NINE);  // fifth digit hits the limit
		send_key(KEY_SWITCH);
		send_key(KEY_SWITCH);     // ignored during item entry
		send_key(KEY_ZERO);
		send_key(KEY_ZERO + 8'd7);
		send_key(KEY_ADD);
		send_key(KEY_SWITCH);
		send_key(KEY_COMPLETE);   // entry with zero values, cart done
		send_key(KEY_CANCEL);     // cancel of an empty cart
		send_key(KEY_ZERO + 8'd5);
		send_key(KEY_SWITCH);
		send_key(KEY_ZERO + 8'd3);
		send_key(KEY_CANCEL);     // cancel with a partial entry
		send_key(8'hA5);
		send_key(8'h5A);
		drain_events();
	endtask

	// digit limits of one and the 16-bit maximum
	task automatic test_limit_extremes();
		write_limit(16'd1);
		send_random_keys(100);
		write_limit(16'hFFFF);
		send_random_keys(100);
		write_limit(LIMIT_RESET);
	endtask

	// carts filled to the maximum, stray keys, then complete or cancel
	task automatic test_full_cart();
		for (int c = 0; c < 3; c++) begin
			for (int e = 0; e < CART_MAX; e++) begin
				send_digits($urandom_range(2));
				send_key(KEY_SWITCH);
				send_digits($urandom_range(2));
				send_key(KEY_ADD);
			end
			repeat (3) send_key(8'($urandom_range(255)));
			send_key((c == 1) ? KEY_CANCEL : KEY_COMPLETE);
		end
		drain_events();
	endtask

	// random limits with random key streams
	task automatic test_random(input int unsigned phases);
		repeat (phases) begin
			write_limit(16'($urandom_range(65535, 1)));
			send_random_keys(150);
		end
		drain_events();
	endtask

	// receiver holds off while entries keep coming, so the input side stalls
	task automatic test_backpressure();
		drain_events();
		hold_requests++;
		repeat (40) begin
			send_key(KEY_SWITCH);
			send_key(KEY_ADD);
			if (cart_count >= CART_MAX)
				send_key(KEY_COMPLETE);
		end
		drain_events();
	endtask

	initial begin
		cart_limit = LIMIT_RESET;
		clear_cart();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 70;
		test_directed();
		test_limit_extremes();
		test_full_cart();

		send_idle_pct = 70;
		recv_idle_pct = 21;
		test_random(3);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(3);
		test_backpressure();

		drain_events();
		if (fails == 0)
			$display("keypad_cart_entry_parser regression: pass");
		else
			$display("keypad_cart_entry_parser regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#(5_000_000);
		$display("keypad_cart_entry_parser regression: fail");
		$finish;
	end

endmodule
